// ===== sv/dvc_pkg.sv =====
// Shared constants, types and unit interfaces of the dual-voice crossfade controller.
package dvc_pkg;

    // Widths of the identifiers, the time base and the gain fraction.
    localparam int CLIP_ID_BITS   = 8;
    localparam int TIME_BITS      = 24;
    localparam int GAIN_FRAC_BITS = 15;

    // Derived widths.
    localparam int GAIN_W     = GAIN_FRAC_BITS + 1;
    localparam int ELAPSED_W  = TIME_BITS + 1;
    localparam int STEP_W     = 16;
    localparam int SUM_W      = ((ELAPSED_W > STEP_W) ? ELAPSED_W : STEP_W) + 1;
    localparam int MUL_CNT_W  = $clog2(GAIN_W);
    localparam int DIV_CNT_W  = (GAIN_FRAC_BITS > 1) ? $clog2(GAIN_FRAC_BITS) : 1;

    // Unity gain.
    localparam logic [GAIN_W-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

    // Event codes carried by the action field.
    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_PLAY   = 3'd1,
        ACT_STOP   = 3'd2,
        ACT_PAUSE  = 3'd3,
        ACT_RESUME = 3'd4
    } action_t;

    // Run state of one voice.
    typedef enum logic [1:0] {
        RUN_STOPPED = 2'd0,
        RUN_PLAYING = 2'd1,
        RUN_PAUSED  = 2'd2
    } run_t;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_DIV,
        S_SEC,
        S_SCALE,
        S_DONE
    } state_t;

    // Request and response of the serial gain multiplier.
    typedef struct packed {
        logic              start;
        logic [GAIN_W-1:0] a;
        logic [GAIN_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              done;
        logic [GAIN_W-1:0] result;
    } mul_rsp_t;

    // Request and response of the serial ratio divider.
    typedef struct packed {
        logic                 start;
        logic [TIME_BITS-1:0] dividend;
        logic [TIME_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic [GAIN_FRAC_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== sv/dvc_serial_mul.sv =====
// Bit-serial shift-add gain multiplier returning (a * b) >> GAIN_FRAC_BITS.
module dvc_serial_mul
    import dvc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mul_req_t req,
    output mul_rsp_t rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [MUL_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [GAIN_W-1:0]      a_reg, a_next;
    logic [2*GAIN_W-1:0]    prod_reg, prod_next;
    logic [GAIN_W:0]        partial;
    logic                   last;

    // One multiplier bit per cycle: add the multiplicand into the upper half
    // when the current low bit is set, then shift the whole product right.
    assign partial = {1'b0, prod_reg[2*GAIN_W-1:GAIN_W]}
                   + (prod_reg[0] ? {1'b0, a_reg} : {(GAIN_W+1){1'b0}});
    assign last    = (cnt_reg == MUL_CNT_W'(GAIN_W - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        prod_next = prod_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            a_next    = req.a;
            prod_next = {{GAIN_W{1'b0}}, req.b};
        end
        else if (busy_reg)
        begin
            prod_next = {partial, prod_reg[GAIN_W-1:1]};
            cnt_next  = cnt_reg + MUL_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        prod_reg <= prod_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = prod_reg[GAIN_W+GAIN_FRAC_BITS-1:GAIN_FRAC_BITS];

endmodule

// ===== sv/dvc_serial_div.sv =====
// Restoring bit-serial divider for the crossfade ratio (dividend << GAIN_FRAC_BITS) / divisor.
module dvc_serial_div
    import dvc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;
    logic [DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic [TIME_BITS-1:0]      rem_reg, rem_next;
    logic [TIME_BITS-1:0]      dvs_reg, dvs_next;
    logic [GAIN_FRAC_BITS-1:0] quo_reg, quo_next;
    logic [TIME_BITS:0]        rem_shift;
    logic [TIME_BITS:0]        rem_diff;
    logic                      fits;
    logic                      last;

    // The dividend is below the divisor, so every partial remainder stays
    // below the divisor and one quotient bit falls out per cycle.
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_diff  = rem_shift - {1'b0, dvs_reg};
    assign fits      = (rem_shift >= {1'b0, dvs_reg});
    assign last      = (cnt_reg == DIV_CNT_W'(GAIN_FRAC_BITS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.dividend;
            dvs_next  = req.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
            quo_next = {quo_reg[GAIN_FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== sv/dual_voice_crossfade_controller_top.sv =====
// Top level of the dual-voice crossfade controller: event sequencer, voice state and output word.
// Play, stop, pause, resume and the unknown codes go straight to the result; an idle tick runs one
// master-gain multiply, a tick that ends a fade the secondary gain product and then the scaling,
// other fade ticks the ratio division first. One word at a time; the serial units set the ticks.
// Reset (rst_n low, asynchronous) stops both voices, clears all gains, clips and the fade,
// makes slot A primary and sets the master gain to unity.
module dual_voice_crossfade_controller_top
    import dvc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    // Configuration write channel: the master gain.
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [GAIN_W-1:0]         master_gain,

    // Event input channel.
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                action,
    input  logic [STEP_W-1:0]         time_step,
    input  logic [TIME_BITS-1:0]      fade_length,
    input  logic [CLIP_ID_BITS-1:0]   clip_id,

    // Result output channel.
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      primary_slot,
    output logic [GAIN_W-1:0]         slot_a_level,
    output logic [GAIN_W-1:0]         slot_b_level,
    output logic [1:0]                slot_a_run,
    output logic [1:0]                slot_b_run,
    output logic [CLIP_ID_BITS-1:0]   slot_a_clip,
    output logic [CLIP_ID_BITS-1:0]   slot_b_clip,
    output logic                      fading,
    output logic                      pause_granted
);

    // Sequencer state.
    state_t                    state_reg, state_next;

    // Latched event word.
    logic [2:0]                act_reg, act_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [TIME_BITS-1:0]      fade_reg, fade_next;
    logic [CLIP_ID_BITS-1:0]   clip_in_reg, clip_in_next;

    // Voice and fade state.
    logic [GAIN_W-1:0]         master_reg;
    logic                      pri_reg, pri_next;
    logic [GAIN_W-1:0]         gain_reg [2];
    logic [GAIN_W-1:0]         gain_next [2];
    logic [GAIN_W-1:0]         level_reg [2];
    logic [GAIN_W-1:0]         level_next [2];
    logic [CLIP_ID_BITS-1:0]   clip_reg [2];
    logic [CLIP_ID_BITS-1:0]   clip_next [2];
    run_t                      run_reg [2];
    run_t                      run_next [2];
    logic                      active_reg, active_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic [TIME_BITS-1:0]      total_reg, total_next;
    logic [GAIN_W-1:0]         fsg_reg, fsg_next;
    logic [GAIN_W-1:0]         ratio_reg, ratio_next;
    logic                      granted_reg, granted_next;

    // Output word.
    logic                      out_valid_reg, out_valid_next;
    logic                      o_pri_reg;
    logic [GAIN_W-1:0]         o_level_a_reg, o_level_b_reg;
    run_t                      o_run_a_reg, o_run_b_reg;
    logic [CLIP_ID_BITS-1:0]   o_clip_a_reg, o_clip_b_reg;
    logic                      o_fading_reg, o_granted_reg;

    // Arithmetic unit handshakes.
    mul_req_t                  mul0_req, mul1_req;
    mul_rsp_t                  mul0_rsp, mul1_rsp;
    div_req_t                  div_req;
    div_rsp_t                  div_rsp;

    logic                      accept;
    logic                      out_load;
    logic                      sec_idx;
    logic [GAIN_W-1:0]         gain_pri, gain_sec;
    run_t                      run_pri;
    logic [SUM_W-1:0]          elapsed_sum;
    logic [ELAPSED_W-1:0]      elapsed_sat;
    logic                      reached_new;
    logic                      reached_now;

    assign accept    = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // The secondary voice is always the slot that is not primary.
    assign sec_idx  = ~pri_reg;
    assign gain_pri = pri_reg ? gain_reg[1] : gain_reg[0];
    assign gain_sec = pri_reg ? gain_reg[0] : gain_reg[1];
    assign run_pri  = pri_reg ? run_reg[1] : run_reg[0];

    // Elapsed time after a tick, saturating at the top of its range.
    assign elapsed_sum = SUM_W'(elapsed_reg) + SUM_W'(step_reg);
    assign elapsed_sat = (|elapsed_sum[SUM_W-1:ELAPSED_W]) ? {ELAPSED_W{1'b1}}
                                                           : elapsed_sum[ELAPSED_W-1:0];
    // The fade is complete once elapsed time reaches the fade length.
    assign reached_new = (elapsed_sat >= ELAPSED_W'(total_reg));
    assign reached_now = (elapsed_reg >= ELAPSED_W'(total_reg));

    dvc_serial_mul u_mul0
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul0_req),
        .rsp   (mul0_rsp)
    );

    dvc_serial_mul u_mul1
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul1_req),
        .rsp   (mul1_rsp)
    );

    dvc_serial_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Next-state logic of the sequencer. A tick with no fade only rescales the
    // primary voice; a tick during a fade runs the ratio division (unless the
    // fade just completed), then the secondary gain product, then the scaling
    // of both voices by the master gain.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (act_reg == ACT_TICK)
                begin
                    if (!active_reg)
                    begin
                        state_next = S_SCALE;
                    end
                    else if (reached_new)
                    begin
                        state_next = S_SEC;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = S_SEC;
                end
            end
            S_SEC:
            begin
                if (mul0_rsp.done)
                begin
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                if (mul0_rsp.done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: start pulses and operands of the serial units.
    always_comb
    begin
        mul0_req = '0;
        mul1_req = '0;
        div_req  = '0;
        unique case (state_reg)
            S_EXEC:
            begin
                if (act_reg == ACT_TICK)
                begin
                    if (!active_reg)
                    begin
                        mul0_req.start = 1'b1;
                        mul0_req.a     = gain_pri;
                        mul0_req.b     = master_reg;
                    end
                    else if (reached_new)
                    begin
                        // Ratio is one, so the secondary gain falls to zero.
                        mul0_req.start = 1'b1;
                        mul0_req.a     = fsg_reg;
                        mul0_req.b     = '0;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = elapsed_sat[TIME_BITS-1:0];
                        div_req.divisor  = total_reg;
                    end
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    mul0_req.start = 1'b1;
                    mul0_req.a     = fsg_reg;
                    mul0_req.b     = GAIN_ONE - GAIN_W'(div_rsp.quotient);
                end
            end
            S_SEC:
            begin
                if (mul0_rsp.done)
                begin
                    mul0_req.start = 1'b1;
                    mul0_req.a     = ratio_reg;
                    mul0_req.b     = master_reg;
                    mul1_req.start = 1'b1;
                    mul1_req.a     = mul0_rsp.result;
                    mul1_req.b     = master_reg;
                end
            end
            default:
            begin
                mul0_req = '0;
            end
        endcase
    end

    // Voice state updates for each event and each step of a tick.
    always_comb
    begin
        act_next     = act_reg;
        step_next    = step_reg;
        fade_next    = fade_reg;
        clip_in_next = clip_in_reg;
        pri_next     = pri_reg;
        gain_next    = gain_reg;
        level_next   = level_reg;
        clip_next    = clip_reg;
        run_next     = run_reg;
        active_next  = active_reg;
        elapsed_next = elapsed_reg;
        total_next   = total_reg;
        fsg_next     = fsg_reg;
        ratio_next   = ratio_reg;
        granted_next = granted_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next     = action;
                    step_next    = time_step;
                    fade_next    = fade_length;
                    clip_in_next = clip_id;
                end
            end
            S_EXEC:
            begin
                granted_next = 1'b0;
                case (act_reg)
                    ACT_TICK:
                    begin
                        if (active_reg)
                        begin
                            elapsed_next = elapsed_sat;
                            if (reached_new)
                            begin
                                ratio_next = GAIN_ONE;
                            end
                        end
                    end
                    ACT_PLAY:
                    begin
                        // Roles swap: the old secondary slot becomes primary.
                        pri_next           = sec_idx;
                        clip_next[sec_idx] = clip_in_reg;
                        run_next[sec_idx]  = RUN_PLAYING;
                        if (fade_reg == '0)
                        begin
                            run_next[pri_reg]   = RUN_STOPPED;
                            gain_next[sec_idx]  = GAIN_ONE;
                            level_next[sec_idx] = master_reg;
                            active_next         = 1'b0;
                        end
                        else
                        begin
                            gain_next[sec_idx]  = '0;
                            level_next[sec_idx] = '0;
                            active_next         = 1'b1;
                            elapsed_next        = '0;
                            total_next          = fade_reg;
                            fsg_next            = gain_pri;
                        end
                    end
                    ACT_STOP:
                    begin
                        run_next[sec_idx] = RUN_STOPPED;
                        if ((run_pri == RUN_PAUSED) || (fade_reg == '0))
                        begin
                            run_next[pri_reg] = RUN_STOPPED;
                            active_next       = 1'b0;
                        end
                        else
                        begin
                            // The old primary becomes secondary and fades out.
                            pri_next     = sec_idx;
                            active_next  = 1'b1;
                            elapsed_next = '0;
                            total_next   = fade_reg;
                            fsg_next     = gain_pri;
                        end
                    end
                    ACT_PAUSE:
                    begin
                        if (run_pri == RUN_PLAYING)
                        begin
                            run_next[pri_reg] = RUN_PAUSED;
                            granted_next      = 1'b1;
                        end
                    end
                    ACT_RESUME:
                    begin
                        run_next[pri_reg] = RUN_PLAYING;
                    end
                    default:
                    begin
                        granted_next = 1'b0;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    ratio_next = GAIN_W'(div_rsp.quotient);
                end
            end
            S_SEC:
            begin
                if (mul0_rsp.done)
                begin
                    gain_next[pri_reg] = ratio_reg;
                    gain_next[sec_idx] = mul0_rsp.result;
                end
            end
            S_SCALE:
            begin
                if (mul0_rsp.done)
                begin
                    level_next[pri_reg] = mul0_rsp.result;
                    if (active_reg)
                    begin
                        level_next[sec_idx] = mul1_rsp.result;
                        if (reached_now)
                        begin
                            run_next[sec_idx] = RUN_STOPPED;
                            active_next       = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
                granted_next = granted_reg;
            end
        endcase
    end

    // The result word is held until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            master_reg    <= GAIN_ONE;
            pri_reg       <= 1'b0;
            gain_reg      <= '{default: '0};
            level_reg     <= '{default: '0};
            clip_reg      <= '{default: '0};
            run_reg       <= '{default: RUN_STOPPED};
            active_reg    <= 1'b0;
            elapsed_reg   <= '0;
            total_reg     <= '0;
            fsg_reg       <= '0;
            ratio_reg     <= '0;
            granted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            // A master gain above unity is clipped to unity.
            if (cfg_valid && cfg_ready)
            begin
                master_reg <= (master_gain > GAIN_ONE) ? GAIN_ONE : master_gain;
            end
            pri_reg       <= pri_next;
            gain_reg      <= gain_next;
            level_reg     <= level_next;
            clip_reg      <= clip_next;
            run_reg       <= run_next;
            active_reg    <= active_next;
            elapsed_reg   <= elapsed_next;
            total_reg     <= total_next;
            fsg_reg       <= fsg_next;
            ratio_reg     <= ratio_next;
            granted_reg   <= granted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg     <= act_next;
        step_reg    <= step_next;
        fade_reg    <= fade_next;
        clip_in_reg <= clip_in_next;
        if (out_load)
        begin
            o_pri_reg     <= pri_reg;
            o_level_a_reg <= level_reg[0];
            o_level_b_reg <= level_reg[1];
            o_run_a_reg   <= run_reg[0];
            o_run_b_reg   <= run_reg[1];
            o_clip_a_reg  <= clip_reg[0];
            o_clip_b_reg  <= clip_reg[1];
            o_fading_reg  <= active_reg;
            o_granted_reg <= granted_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign primary_slot  = o_pri_reg;
    assign slot_a_level  = o_level_a_reg;
    assign slot_b_level  = o_level_b_reg;
    assign slot_a_run    = o_run_a_reg;
    assign slot_b_run    = o_run_b_reg;
    assign slot_a_clip   = o_clip_a_reg;
    assign slot_b_clip   = o_clip_b_reg;
    assign fading        = o_fading_reg;
    assign pause_granted = o_granted_reg;

endmodule

// ===== sv/dvc_checker.sv =====
// Port-level assertions of the dual-voice crossfade controller and their bind statement.
module dvc_checker
    import dvc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input logic              primary_slot,
    input logic [GAIN_W-1:0] slot_a_level,
    input logic [GAIN_W-1:0] slot_b_level,
    input logic [1:0]        slot_a_run,
    input logic [1:0]        slot_b_run,
    input logic              pause_granted
);

    // A word that waits on the output is not withdrawn.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result word dropped while stalled");

    // One word is worked on at a time, so the input stalls right after an accept.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("second word accepted while one is in flight");

    // Applied levels never exceed unity gain.
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (slot_a_level <= GAIN_ONE) && (slot_b_level <= GAIN_ONE))
        else $error("applied level above unity");

    // A granted pause leaves the primary voice paused.
    a_pause_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pause_granted |->
            ((primary_slot ? slot_b_run : slot_a_run) == RUN_PAUSED))
        else $error("pause granted but primary voice not paused");

endmodule

bind dual_voice_crossfade_controller_top dvc_checker u_dvc_checker (.*);
